@@ rtl/core/tdwq_pkg.sv @@
// ----------------------------------------------------------------------------
// tdwq_pkg
// Shared widths, codes and types of the tick delay wakeup queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tdwq_pkg;

  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int TASK_W    = 8;
  localparam int TICK_W    = 31;
  localparam int MAX_TASKS_DEF = 32;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_DELAY = 2'd1,
    OP_TIME  = 2'd2,
    OP_UNTIL = 2'd3
  } op_t;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_WAKE = 2'd1,
    KIND_TIME = 2'd2,
    KIND_FULL = 2'd3
  } kind_t;

  // one queue slot
  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] deadline;
    logic [TASK_W-1:0] tid;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/tdwq_cell.sv @@
// ----------------------------------------------------------------------------
// tdwq_cell
// One slot of the sorted wakeup queue: holds an entry, compares it with the
// broadcast key and takes its own entry, its left or its right neighbor's entry, or the new one built from the key.
// ----------------------------------------------------------------------------
`default_nettype none

module tdwq_cell (
  input  wire                          clk,
  input  wire                          rst,
  input  tdwq_pkg::cell_cmd_t          cmd,
  input  wire [tdwq_pkg::TICK_W-1:0]   key,
  input  wire [tdwq_pkg::TASK_W-1:0]   new_tid,
  input  tdwq_pkg::entry_t             prev,
  input  wire                          prev_stay,
  input  tdwq_pkg::entry_t             next,
  output tdwq_pkg::entry_t             entry,
  output logic                         stay
);
  import tdwq_pkg::*;

  logic              valid;
  logic [TICK_W-1:0] deadline;
  logic [TASK_W-1:0] tid;
  entry_t            entry_next;

  // entry stays put on insert when its deadline is at or below the key
  assign stay  = valid && (deadline <= key);
  assign entry = '{valid: valid, deadline: deadline, tid: tid};

  // select the entry held after this cycle
  always_comb begin
    entry_next = entry;
    priority if (cmd.shift) begin
      entry_next = next;
    end else if (cmd.insert && !stay) begin
      if (prev_stay) begin
        entry_next = '{valid: 1'b1, deadline: key, tid: new_tid};
      end else begin
        entry_next = prev;
      end
    end else begin
      entry_next = entry;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    deadline <= entry_next.deadline;
    tid      <= entry_next.tid;
  end

endmodule

`default_nettype wire

@@ rtl/core/tick_delay_wakeup_queue_core.sv @@
// ----------------------------------------------------------------------------
// tick_delay_wakeup_queue_core
// Tick counter with a sorted queue of pending task wakeups.
// ----------------------------------------------------------------------------
// The block takes one request at a time. For a time query, a delay or an
// absolute delay the accepting edge latches the request and forms the key;
// then the queue's chain of cells, where every slot compares its deadline
// with the key in parallel, takes an insert that shifts the tail by one slot,
// or the block registers the result, where there is one. A tick is
// acknowledged first; then each task that it releases leaves from the head
// cell, the earliest first, and the chain shifts by one slot per cycle while
// results are taken. A result that is not taken holds the block in place
// until it is. The queue holds MAX_TASKS entries; a delay or an absolute
// delay that finds it full is answered with a queue full result.
// Counter and deadlines saturate at 2^31-1.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_delay_wakeup_queue_core #(
  parameter int MAX_TASKS = tdwq_pkg::MAX_TASKS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [tdwq_pkg::OP_W-1:0]     operation,
  input  wire [tdwq_pkg::TASK_W-1:0]   task_id,
  input  wire [tdwq_pkg::TICK_W-1:0]   ticks,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [tdwq_pkg::KIND_W-1:0]  kind,
  output logic [tdwq_pkg::TASK_W-1:0]  task_id_res,
  output logic [tdwq_pkg::TICK_W-1:0]  ticks_res,
  output logic                         last
);
  import tdwq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RELEASE
  } state_t;

  state_t            state;
  state_t            state_next;
  op_t               op_q;
  logic [TASK_W-1:0] tid_q;
  logic [TICK_W-1:0] key;
  logic [TICK_W-1:0] count;

  logic [TICK_W-1:0] count_inc;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] sum_sat;
  logic [TICK_W-1:0] key_next;
  logic              accept;
  logic              slot_free;

  logic              emit;
  kind_t             emit_kind;
  logic [TASK_W-1:0] emit_tid;
  logic [TICK_W-1:0] emit_ticks;
  logic              emit_last;
  cell_cmd_t         cmd;

  entry_t                cell_q    [MAX_TASKS];
  entry_t                prev_e    [MAX_TASKS];
  entry_t                next_e    [MAX_TASKS];
  logic [MAX_TASKS-1:0]  stay;
  logic [MAX_TASKS-1:0]  prev_stay;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // saturating counter step and deadline sum
  assign count_inc = (count == TICK_MAX) ? count : count + TICK_W'(1);
  assign sum       = {1'b0, count} + {1'b0, ticks};
  assign sum_sat   = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];

  // key broadcast to the cells
  always_comb begin
    unique case (op_t'(operation))
      OP_TICK:  key_next = count_inc;
      OP_DELAY: key_next = sum_sat;
      OP_UNTIL: key_next = ticks;
      OP_TIME:  key_next = count;
      default:  key_next = count;
    endcase
  end

  // chain of queue cells
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_e[i]    = '0;
      assign prev_stay[i] = 1'b1;
    end else begin : g_body
      assign prev_e[i]    = cell_q[i-1];
      assign prev_stay[i] = stay[i-1];
    end
    if (i == MAX_TASKS - 1) begin : g_tail
      assign next_e[i] = '0;
    end else begin : g_inner
      assign next_e[i] = cell_q[i+1];
    end

    tdwq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .key       (key),
      .new_tid   (tid_q),
      .prev      (prev_e[i]),
      .prev_stay (prev_stay[i]),
      .next      (next_e[i]),
      .entry     (cell_q[i]),
      .stay      (stay[i])
    );
  end

  // sequencing of one request
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_kind  = KIND_ACK;
    emit_tid   = tid_q;
    emit_ticks = '0;
    emit_last  = 1'b1;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_TICK: begin
            if (slot_free) begin
              emit       = 1'b1;
              emit_kind  = KIND_ACK;
              emit_last  = !stay[0];
              state_next = stay[0] ? S_RELEASE : S_IDLE;
            end
          end
          OP_TIME: begin
            if (slot_free) begin
              emit       = 1'b1;
              emit_kind  = KIND_TIME;
              emit_ticks = count;
              state_next = S_IDLE;
            end
          end
          OP_DELAY, OP_UNTIL: begin
            priority if (op_q == OP_UNTIL && key <= count) begin
              // deadline already reached
              if (slot_free) begin
                emit       = 1'b1;
                emit_kind  = KIND_WAKE;
                state_next = S_IDLE;
              end
            end else if (cell_q[MAX_TASKS-1].valid) begin
              if (slot_free) begin
                emit       = 1'b1;
                emit_kind  = KIND_FULL;
                state_next = S_IDLE;
              end
            end else begin
              cmd.insert = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RELEASE: begin
        // head entry is due: hand it out and shift the chain
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_WAKE;
          emit_tid   = cell_q[0].tid;
          emit_last  = !stay[1];
          cmd.shift  = 1'b1;
          state_next = stay[1] ? S_RELEASE : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && op_t'(operation) == OP_TICK) begin
        count <= count_inc;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_t'(operation);
      tid_q <= task_id;
      key   <= key_next;
    end
    if (emit) begin
      kind        <= emit_kind;
      task_id_res <= emit_tid;
      ticks_res   <= emit_ticks;
      last        <= emit_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tdwq_checker.sv @@
// ----------------------------------------------------------------------------
// tdwq_checker
// Port level checks of the tick delay wakeup queue, bound to the queue core.
// ----------------------------------------------------------------------------
`default_nettype none

module tdwq_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire [tdwq_pkg::OP_W-1:0]     operation,
  input wire [tdwq_pkg::TASK_W-1:0]   task_id,
  input wire [tdwq_pkg::TICK_W-1:0]   ticks,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [tdwq_pkg::KIND_W-1:0]   kind,
  input wire [tdwq_pkg::TASK_W-1:0]   task_id_res,
  input wire [tdwq_pkg::TICK_W-1:0]   ticks_res,
  input wire                          last
);
  import tdwq_pkg::*;

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(task_id)
      && $stable(ticks))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(task_id_res)
      && $stable(ticks_res) && $stable(last))
    else $error("result changed while stalled");

  // one request at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // only a time reply carries a counter value
  a_ticks_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_TIME |-> ticks_res == '0)
    else $error("nonzero ticks in non-time result");

  // time reply and queue full are single results
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_TIME || kind == KIND_FULL) |-> last)
    else $error("single result not marked last");

endmodule

bind tick_delay_wakeup_queue_core tdwq_checker u_tdwq_checker (.*);

`default_nettype wire
